### hdl/rav_pkg.sv
`timescale 1ns / 1ps

package rav_pkg;

  localparam int CFG_BITS        = 6;
  localparam int AVG_BITS        = 16;
  localparam int DEFAULT_WINDOW  = 20;
  localparam int DEF_MAX_WINDOW  = 32;
  localparam int DEF_SAMPLE_BITS = 16;

  typedef struct packed {
    logic clear;
    logic rd_en;
    logic wr_en;
  } rav_store_ctl_t;

endpackage

### hdl/rav_store.sv
`timescale 1ns / 1ps

module rav_store #(
  parameter int MAX_WINDOW  = rav_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = rav_pkg::DEF_SAMPLE_BITS,
  parameter int CNT_BITS    = 6,
  parameter int SUM_BITS    = 21
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rav_pkg::rav_store_ctl_t ctl,
  input  logic [CNT_BITS-1:0]    len,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic [SUM_BITS-1:0]    sum_nxt,
  output logic [CNT_BITS-1:0]    cnt_nxt
);
  import rav_pkg::*;

  localparam int POS_BITS = $clog2(MAX_WINDOW);
  localparam int CMP_BITS = (POS_BITS + 1 > CNT_BITS) ? POS_BITS + 1 : CNT_BITS;

  logic [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] rd_data_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic [SUM_BITS-1:0]    sum_r;
  logic [POS_BITS-1:0]    pos_r;
  logic [POS_BITS-1:0]    pos_nxt;
  logic [CNT_BITS-1:0]    cnt_r;
  logic [POS_BITS:0]      pos_inc;
  logic [SAMPLE_BITS-1:0] old_val;

  // entry at pos_r holds a sample only once the window has filled
  assign old_val = (cnt_r == len) ? rd_data_r : '0;
  assign sum_nxt = sum_r - SUM_BITS'(old_val) + SUM_BITS'(sample_r);
  assign pos_inc = {1'b0, pos_r} + {{POS_BITS{1'b0}}, 1'b1};
  assign pos_nxt = (CMP_BITS'(pos_inc) == CMP_BITS'(len)) ? '0 : pos_inc[POS_BITS-1:0];
  assign cnt_nxt = (cnt_r < len) ? cnt_r + CNT_BITS'(1) : cnt_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[pos_r] <= sample_r;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[pos_r];
      sample_r  <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      sum_r <= '0;
      pos_r <= '0;
      cnt_r <= '0;
    end else if (ctl.wr_en) begin
      sum_r <= sum_nxt;
      pos_r <= pos_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### hdl/rav_div.sv
`timescale 1ns / 1ps

module rav_div #(
  parameter int DIVIDEND_BITS = 21,
  parameter int DIVISOR_BITS  = 6
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [DIVISOR_BITS-1:0]  divisor,
  output logic                     done,
  output logic [DIVIDEND_BITS-1:0] quotient
);

  localparam int STEP_BITS = $clog2(DIVIDEND_BITS + 1);

  logic [DIVIDEND_BITS-1:0] quo_r;
  logic [DIVISOR_BITS-1:0]  rem_r;
  logic [DIVISOR_BITS-1:0]  dvs_r;
  logic [STEP_BITS-1:0]     step_r;
  logic [DIVISOR_BITS:0]    shifted;
  logic [DIVISOR_BITS:0]    diff;
  logic                     ge;

  assign shifted  = {rem_r, quo_r[DIVIDEND_BITS-1]};
  assign ge       = shifted >= {1'b0, dvs_r};
  assign diff     = shifted - {1'b0, dvs_r};
  assign done     = (step_r == '0);
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (!done) begin
      quo_r <= {quo_r[DIVIDEND_BITS-2:0], ge};
      rem_r <= ge ? diff[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (start) begin
      step_r <= STEP_BITS'(DIVIDEND_BITS);
    end else if (!done) begin
      step_r <= step_r - STEP_BITS'(1);
    end
  end

endmodule

### hdl/running_average_filter.sv
`timescale 1ns / 1ps

// Moving average over the last window_length samples (zero reads as one,
// values above the store depth saturate). One sample is taken at a time. After
// the accepting edge, the RMW state updates sum, store and fill count and
// starts the bit-serial divider, which sets the rate; the DIV state waits for
// the divider and loads the output register once that register is free. The
// next sample is taken only after that load. The output register lets the
// next sample in while a result waits.
// A write of window_length clears the window at once; there is no clearing
// pass, since the fill count masks entries not yet written.

module running_average_filter #(
  parameter int MAX_WINDOW  = rav_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = rav_pkg::DEF_SAMPLE_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [SAMPLE_BITS-1:0]       in_sample,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [rav_pkg::AVG_BITS-1:0] out_average,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rav_pkg::CFG_BITS-1:0] cfg_data
);
  import rav_pkg::*;

  localparam int CFG_MAX  = (1 << CFG_BITS) - 1;
  localparam int MAX_LEN  = (MAX_WINDOW < CFG_MAX) ? MAX_WINDOW : CFG_MAX;
  localparam int CNT_BITS = $clog2(MAX_LEN + 1);
  localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_LEN);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RMW  = 3'b010,
    ST_DIV  = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [CFG_BITS-1:0]   window_length_r;
  logic [CNT_BITS-1:0]   len;
  rav_store_ctl_t        ctl;
  logic [SUM_BITS-1:0]   sum_nxt;
  logic [CNT_BITS-1:0]   cnt_nxt;
  logic                  div_done;
  logic [SUM_BITS-1:0]   quotient;
  logic                  in_accept;
  logic                  out_load;
  logic                  out_valid_r;
  logic [AVG_BITS-1:0]   out_average_r;

  always_comb begin
    if (window_length_r == '0) begin
      len = CNT_BITS'(1);
    end else if (window_length_r > CFG_BITS'(MAX_LEN)) begin
      len = CNT_BITS'(MAX_LEN);
    end else begin
      len = CNT_BITS'(window_length_r);
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = (state_r == ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load  = (state_r == ST_DIV) && div_done && (!out_valid_r || !out_stall);

  assign ctl.clear = cfg_valid && cfg_ready;
  assign ctl.rd_en = in_accept;
  assign ctl.wr_en = (state_r == ST_RMW);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) state_nxt = ST_RMW;
      end
      ST_RMW: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      window_length_r <= CFG_BITS'(DEFAULT_WINDOW);
      out_valid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ctl.clear) begin
        window_length_r <= cfg_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_average_r <= AVG_BITS'(quotient);
    end
  end

  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;

  rav_store #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS),
    .CNT_BITS   (CNT_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .len    (len),
    .sample (in_sample),
    .sum_nxt(sum_nxt),
    .cnt_nxt(cnt_nxt)
  );

  rav_div #(
    .DIVIDEND_BITS(SUM_BITS),
    .DIVISOR_BITS (CNT_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (ctl.wr_en),
    .dividend(sum_nxt),
    .divisor (cnt_nxt),
    .done    (div_done),
    .quotient(quotient)
  );

endmodule

### hdl/rav_checker.sv
`timescale 1ns / 1ps

module rav_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [rav_pkg::AVG_BITS-1:0] out_average,
  input logic                         cfg_valid,
  input logic                         cfg_ready
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat pending after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_average))
    else $error("stalled result beat changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall && !cfg_ready)
    else $error("sample taken while previous one in flight");

  a_cfg_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |-> !in_stall)
    else $error("window write accepted while busy");

endmodule

bind running_average_filter rav_checker u_rav_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_average(out_average),
  .cfg_valid  (cfg_valid),
  .cfg_ready  (cfg_ready)
);

### dv/running_average_filter_tb.sv
`timescale 1ns / 1ps

module running_average_filter_tb;
  import rav_pkg::*;

  localparam int STORE_DEPTH = DEF_MAX_WINDOW;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LONG_HOLD = 300;
  localparam int RANDOM_ITEMS = 950;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [DEF_SAMPLE_BITS-1:0] in_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [AVG_BITS-1:0] out_average;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_BITS-1:0] cfg_data = '0;

  // predictor state
  logic [CFG_BITS-1:0] win_len = CFG_BITS'(DEFAULT_WINDOW);
  logic [DEF_SAMPLE_BITS-1:0] window_samples [STORE_DEPTH];
  int unsigned window_sum;
  int unsigned next_slot;
  int unsigned held_count;

  logic [DEF_SAMPLE_BITS-1:0] sample_queue [$];
  logic [AVG_BITS-1:0] avg_expected [$];

  logic steady = 1'b0;
  int err_count = 0;
  int results_seen = 0;
  int hold_left = 0;
  logic long_hold_done = 1'b0;
  int quiet_cycles = 0;

  running_average_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample  (in_sample),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_average(out_average),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always #1 clk = ~clk;

  task automatic clear_window();
    for (int i = 0; i < STORE_DEPTH; i++) window_samples[i] = '0;
    window_sum = 0;
    next_slot = 0;
    held_count = 0;
  endtask

  function automatic logic [AVG_BITS-1:0] predict_average(input logic [DEF_SAMPLE_BITS-1:0] s);
    int unsigned len;
    len = (win_len == 0) ? 1 : (win_len > STORE_DEPTH) ? STORE_DEPTH : int'(win_len);
    if (next_slot >= len) next_slot = 0;
    window_sum = window_sum - window_samples[next_slot] + s;
    window_samples[next_slot] = s;
    next_slot++;
    if (next_slot >= len) next_slot = 0;
    if (held_count < len) held_count++;
    return AVG_BITS'(window_sum / held_count);
  endfunction

  function automatic logic [DEF_SAMPLE_BITS-1:0] pick_sample(input int mode);
    logic [DEF_SAMPLE_BITS-1:0] v;
    case (mode)
      0: v = DEF_SAMPLE_BITS'($urandom_range(65535));
      1: v = ($urandom_range(9) == 0) ? '0 : '1;
      2: v = DEF_SAMPLE_BITS'($urandom_range(15));
      default: begin
        case ($urandom_range(3))
          0: v = '0;
          1: v = '1;
          2: v = DEF_SAMPLE_BITS'(1);
          default: v = 16'hFFFE;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic set_window(input logic [CFG_BITS-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    win_len = v;
    clear_window();
  endtask

  task automatic drain();
    do @(negedge clk); while (sample_queue.size() != 0 || in_valid || avg_expected.size() != 0);
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) avg_expected.push_back(predict_average(in_sample));
      if (!in_valid || !in_stall) begin
        if (sample_queue.size() != 0 && (steady || $urandom_range(99) >= 34)) begin
          in_valid <= 1'b1;
          in_sample <= sample_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    logic [AVG_BITS-1:0] want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (avg_expected.size() == 0) begin
          $display("%0t: unexpected average beat %0d", $time, out_average);
          err_count++;
        end else begin
          want = avg_expected.pop_front();
          if (out_average !== want) begin
            $display("%0t: average mismatch: expected %0d, actual %0d", $time, want, out_average);
            err_count++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!long_hold_done && results_seen >= 120) begin
        long_hold_done <= 1'b1;
        hold_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < 34);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("running_average_filter_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int sent;
    int n;
    int mode;
    int phase;
    logic [CFG_BITS-1:0] w;
    logic [CFG_BITS-1:0] win_choice [9];

    win_choice = '{6'd32, 6'd63, 6'd1, 6'd3, 6'd31, 6'd33, 6'd0, 6'd20, 6'd16};
    clear_window();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // default window
    sample_queue = '{16'd0, 16'hFFFF, 16'hFFFF, 16'd1, 16'hFFFE, 16'h8000, 16'd12345};
    drain();
    // zero reads as one
    set_window(6'd0);
    sample_queue = '{16'hFFFF, 16'd0, 16'd7};
    drain();
    set_window(6'd1);
    sample_queue = '{16'hFFFF, 16'd3};
    drain();
    set_window(6'd2);
    sample_queue = '{16'hFFFF, 16'hFFFF, 16'd1, 16'd2};
    drain();
    // above store depth saturates
    set_window(6'd33);
    sample_queue = '{16'hFFFF, 16'd4};
    drain();
    set_window(6'd63);
    sample_queue = '{16'd0, 16'hFFFF};
    drain();

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      w = (phase < 9) ? win_choice[phase] : CFG_BITS'($urandom_range(63));
      mode = (phase == 0) ? 1 : $urandom_range(3);
      n = $urandom_range(40, 100);
      if (n > RANDOM_ITEMS - sent) n = RANDOM_ITEMS - sent;
      set_window(w);
      steady <= (phase == 4);
      for (int i = 0; i < n; i++) sample_queue.push_back(pick_sample(mode));
      drain();
      steady <= 1'b0;
      sent += n;
      phase++;
    end

    repeat (60) @(posedge clk);
    @(negedge clk);
    if (err_count == 0) begin
      $display("running_average_filter_tb OK");
    end else begin
      $display("running_average_filter_tb NOT OK");
    end
    $finish;
  end

endmodule

### running_average_filter.f
hdl/rav_pkg.sv
hdl/rav_store.sv
hdl/rav_div.sv
hdl/running_average_filter.sv
hdl/rav_checker.sv
dv/running_average_filter_tb.sv
